/* rtl/core/plpm_pkg.sv */
// ----------------------------------------------------------------------------
// Piecewise linear pixel map package
// Shared sizes, codes and the item record that moves down the scan pipeline.
// ----------------------------------------------------------------------------
package plpm_pkg;

  localparam int MAX_POINTS = 256;
  localparam int IN_BITS    = 16;
  localparam int OUT_BITS   = 8;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 9;
  localparam int NUM_W      = IN_BITS + OUT_BITS + 1;

  // Item kinds carried on the input tuser.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_MAP  = 1'b1;

  // One item on its way through the breakpoint cells.
  typedef struct packed {
    logic                valid;
    logic                is_map;
    logic                last;
    logic [IDX_W-1:0]    idx;
    logic [IN_BITS-1:0]  pt_x;
    logic [OUT_BITS-1:0] pt_y;
    logic [IN_BITS-1:0]  pixel;
    logic                below;
    logic                pend;
    logic [IN_BITS-1:0]  x0;
    logic [OUT_BITS-1:0] y0;
    logic [IN_BITS-1:0]  x1;
    logic [OUT_BITS-1:0] y1;
    logic [OUT_BITS-1:0] yf;
  } scan_item_t;

endpackage

/* rtl/core/plpm_cell.sv */
// ----------------------------------------------------------------------------
// Breakpoint cell
// Holds one breakpoint, takes load items addressed to it and updates the
// segment found so far for map items, one pipeline stage per cell.
// ----------------------------------------------------------------------------
module plpm_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic [plpm_pkg::IDX_W-1:0]          cell_idx,
  input  logic [plpm_pkg::CNT_W-1:0]          n_eff,
  input  plpm_pkg::scan_item_t                in_item,
  output plpm_pkg::scan_item_t                out_item
);
  import plpm_pkg::*;

  logic [IN_BITS-1:0]  ex;
  logic [OUT_BITS-1:0] ey;
  scan_item_t          upd;
  logic                active;

  // Breakpoint storage, written by a load item that names this cell.
  always_ff @(posedge clk) begin
    if (en && in_item.valid && !in_item.is_map && in_item.idx == cell_idx) begin
      ex <= in_item.pt_x;
      ey <= in_item.pt_y;
    end
  end

  // Track the last breakpoint at or below the pixel and the one after it.
  always_comb begin
    upd    = in_item;
    active = in_item.valid && in_item.is_map && ({1'b0, cell_idx} < n_eff);
    if (active) begin
      if (cell_idx == '0) begin
        upd.below = (in_item.pixel < ex);
        upd.yf    = ey;
        upd.x0    = ex;
        upd.y0    = ey;
        upd.pend  = 1'b1;
      end else if (ex <= in_item.pixel) begin
        upd.x0   = ex;
        upd.y0   = ey;
        upd.pend = 1'b1;
      end else if (in_item.pend) begin
        upd.x1   = ex;
        upd.y1   = ey;
        upd.pend = 1'b0;
      end
    end
  end

  // Stage register: valid is control, the rest is payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_item.valid <= 1'b0;
    end else if (en) begin
      out_item.valid <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.is_map <= upd.is_map;
      out_item.last   <= upd.last;
      out_item.idx    <= upd.idx;
      out_item.pt_x   <= upd.pt_x;
      out_item.pt_y   <= upd.pt_y;
      out_item.pixel  <= upd.pixel;
      out_item.below  <= upd.below;
      out_item.pend   <= upd.pend;
      out_item.x0     <= upd.x0;
      out_item.y0     <= upd.y0;
      out_item.x1     <= upd.x1;
      out_item.y1     <= upd.y1;
      out_item.yf     <= upd.yf;
    end
  end

endmodule

/* rtl/core/plpm_interp.sv */
// ----------------------------------------------------------------------------
// Segment interpolator
// Weights the two ordinates of the found segment and divides by its width
// with a pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module plpm_interp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  plpm_pkg::scan_item_t          item,
  output logic                          res_valid,
  output logic [plpm_pkg::OUT_BITS-1:0] res_value,
  output logic                          res_last
);
  import plpm_pkg::*;

  typedef struct packed {
    logic                valid;
    logic                last;
    logic                byp;
    logic [OUT_BITS-1:0] bval;
    logic [IN_BITS-1:0]  den;
    logic [NUM_W-1:0]    rem;
    logic [OUT_BITS-1:0] q;
  } div_t;

  logic                        a_valid, a_last, a_byp;
  logic [OUT_BITS-1:0]         a_bval;
  logic [IN_BITS-1:0]          a_den;
  logic [IN_BITS+OUT_BITS-1:0] a_p1, a_p0;
  logic                        b_valid, b_last, b_byp;
  logic [OUT_BITS-1:0]         b_bval;
  logic [IN_BITS-1:0]          b_den;
  logic [NUM_W-1:0]            b_num;
  logic [IN_BITS-1:0]          d_lo, d_hi;
  div_t                        dv_in [OUT_BITS];
  div_t                        dv_q  [OUT_BITS];

  assign d_lo = item.pixel - item.x0;
  assign d_hi = item.x1 - item.pixel;

  // Stage A: both weighted products and the bypass decision.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_last <= item.last;
      a_byp  <= item.below || item.pend || (item.pixel == item.x0) || (item.x1 <= item.x0);
      a_bval <= item.below ? item.yf : item.y0;
      a_den  <= item.x1 - item.x0;
      a_p1   <= (IN_BITS+OUT_BITS)'(d_lo) * (IN_BITS+OUT_BITS)'(item.y1);
      a_p0   <= (IN_BITS+OUT_BITS)'(d_hi) * (IN_BITS+OUT_BITS)'(item.y0);
    end
  end

  // Stage B: sum of the products.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_last <= a_last;
      b_byp  <= a_byp;
      b_bval <= a_bval;
      b_den  <= a_den;
      b_num  <= NUM_W'(a_p1) + NUM_W'(a_p0);
    end
  end

  always_comb begin
    dv_in[0]       = '0;
    dv_in[0].valid = b_valid;
    dv_in[0].last  = b_last;
    dv_in[0].byp   = b_byp;
    dv_in[0].bval  = b_bval;
    dv_in[0].den   = b_den;
    dv_in[0].rem   = b_num;
  end

  // Divider stages, most significant quotient bit first.
  for (genvar s = 0; s < OUT_BITS; s++) begin : g_div
    localparam int BIT = OUT_BITS - 1 - s;
    logic [NUM_W-1:0] trial;
    div_t             nxt;

    if (s > 0) begin : g_link
      assign dv_in[s] = dv_q[s-1];
    end

    assign trial = NUM_W'(dv_in[s].den) << BIT;

    always_comb begin
      nxt = dv_in[s];
      if (dv_in[s].rem >= trial) begin
        nxt.rem    = dv_in[s].rem - trial;
        nxt.q[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_q[s].valid <= 1'b0;
      end else if (en) begin
        dv_q[s].valid <= nxt.valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_q[s].last <= nxt.last;
        dv_q[s].byp  <= nxt.byp;
        dv_q[s].bval <= nxt.bval;
        dv_q[s].den  <= nxt.den;
        dv_q[s].rem  <= nxt.rem;
        dv_q[s].q    <= nxt.q;
      end
    end
  end

  // The last divider stage is the output register.
  assign res_valid = dv_q[OUT_BITS-1].valid;
  assign res_last  = dv_q[OUT_BITS-1].last;
  assign res_value = dv_q[OUT_BITS-1].byp ? dv_q[OUT_BITS-1].bval : dv_q[OUT_BITS-1].q;

endmodule

/* rtl/core/piecewise_linear_pixel_map.sv */
// ----------------------------------------------------------------------------
// Piecewise linear pixel map
// Maps each pixel through a curve of up to 256 breakpoints loaded in-band.
//
//   Channel   Dir  Content
//   s_*       in   tuser: action; tdata: index, x, y, pixel; tlast: last pixel
//   m_*       out  tdata: mapped value; tlast: last pixel
//   cfg_*     in   point_count register write
//
// One item enters per cycle while the output is not stalled. The path holds 256
// cell stages, 2 interpolation stages and 8 divider stages.
// Load items travel the same row, so each entry changes in item order.
// Reset clears the valid bits and sets the count to one; entries are unset.
// A stall on the output freezes every stage together; nothing is dropped.
// ----------------------------------------------------------------------------
module piecewise_linear_pixel_map (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [plpm_pkg::CNT_W-1:0]    cfg_wr_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [47:0]                   s_tdata,  // point_index, point_x, point_y, pixel
  input  logic                          s_tuser,  // action
  input  logic                          s_tlast,  // last_pixel
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,  // mapped_value
  output logic                          m_tlast   // last_out
);
  import plpm_pkg::*;

  logic [CNT_W-1:0]    point_count;
  logic [CNT_W-1:0]    n_eff;
  logic                en;
  scan_item_t          items [MAX_POINTS+1];
  scan_item_t          tail;
  logic [OUT_BITS-1:0] res_value;

  // Count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= CNT_W'(1);
    end else if (cfg_wr_en) begin
      point_count <= cfg_wr_data;
    end
  end

  // Count in use, clamped to the table.
  always_comb begin
    if (point_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (point_count > CNT_W'(MAX_POINTS)) begin
      n_eff = CNT_W'(MAX_POINTS);
    end else begin
      n_eff = point_count;
    end
  end

  // The whole pipeline advances unless the output holds a result not taken.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Unpack the input transfer into a scan item.
  always_comb begin
    items[0]        = '0;
    items[0].valid  = s_tvalid;
    items[0].is_map = (s_tuser == ACT_MAP);
    items[0].last   = s_tlast;
    items[0].idx    = s_tdata[7:0];
    items[0].pt_x   = s_tdata[23:8];
    items[0].pt_y   = s_tdata[31:24];
    items[0].pixel  = s_tdata[47:32];
  end

  // Row of breakpoint cells.
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    plpm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .cell_idx (IDX_W'(k)),
      .n_eff    (n_eff),
      .in_item  (items[k]),
      .out_item (items[k+1])
    );
  end

  // Only map items go on to the interpolator.
  always_comb begin
    tail       = items[MAX_POINTS];
    tail.valid = items[MAX_POINTS].valid && items[MAX_POINTS].is_map;
  end

  plpm_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .item      (tail),
    .res_valid (m_tvalid),
    .res_value (res_value),
    .res_last  (m_tlast)
  );

  assign m_tdata = 8'(res_value);

  // Checks.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (n_eff != '0) && (n_eff <= CNT_W'(MAX_POINTS)))
    else $error("clamped point count out of range");

  a_reset_empty: assert property (@(posedge clk) (!rst && $past(rst)) |-> !m_tvalid)
    else $error("result valid right after reset");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output stalled");

endmodule
